// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file rtl/bmf_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside of reset.
`define ASSERT_CHECK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check a property on every rising edge, reset cycles included.
`define ASSERT_RESET(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("reset assertion failed");

`endif

// ===== rtl/bmf_pkg.sv =====
`default_nettype none

package bmf_pkg;

    // Field widths of the stream words.
    localparam int ROW_W      = 10;
    localparam int COL_W      = 6;
    localparam int IN_ROW_W   = 11;
    localparam int WIDTH_W    = 7;
    localparam int HEIGHT_W   = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    // Register values after reset.
    localparam int WIDTH_RESET  = 64;
    localparam int HEIGHT_RESET = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    // Input opcodes.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Which neighbors of the output pixel lie inside the frame.
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } t_edge_mask;

    // One result word.
    typedef struct packed {
        logic              pixel;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              last;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/bmf_ram.sv =====
`default_nettype none

module bmf_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port; a read returns the old data.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/bmf_vote.sv =====
`default_nettype none

module bmf_vote (
    input  wire logic [8:0]          i_window,
    input  wire bmf_pkg::t_edge_mask i_edges,
    output logic                     o_pixel
);

    import bmf_pkg::*;

    logic [7:0] neighbor;
    logic [7:0] in_frame;
    logic [3:0] black;
    logic [3:0] total;

    // Window bit is column slot * 3 + row position; the center bit 4 is skipped.
    assign neighbor = {i_window[8], i_window[7], i_window[6], i_window[5],
                       i_window[3], i_window[2], i_window[1], i_window[0]};

    assign in_frame[0] = i_edges.top    & i_edges.left;
    assign in_frame[1] = i_edges.left;
    assign in_frame[2] = i_edges.bottom & i_edges.left;
    assign in_frame[3] = i_edges.top;
    assign in_frame[4] = i_edges.bottom;
    assign in_frame[5] = i_edges.top    & i_edges.right;
    assign in_frame[6] = i_edges.right;
    assign in_frame[7] = i_edges.bottom & i_edges.right;

    // Count black and in-frame neighbors.
    always_comb begin
        black = '0;
        total = '0;
        for (int k = 0; k < 8; k++) begin
            black = black + 4'(neighbor[k] & in_frame[k]);
            total = total + 4'(in_frame[k]);
        end
    end

    // Black wins ties, including the case with no neighbor at all.
    assign o_pixel = ({1'b0, black} << 1) >= {1'b0, total};

endmodule

`default_nettype wire

// ===== rtl/bmf_out_buf.sv =====
`default_nettype none

module bmf_out_buf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire bmf_pkg::t_result i_data,
    output logic                  o_full,
    output logic                  o_valid,
    output bmf_pkg::t_result      o_data,
    input  wire logic             i_stall
);

    import bmf_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    n_out_valid;
    logic    n_skid_valid;
    logic    load_out;
    logic    load_skid;
    logic    out_free;

    // The output register refills when empty or taken; otherwise a new word
    // parks in the skid register.
    always_comb begin
        out_free     = !r_out_valid || !i_stall;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        load_out     = 1'b0;
        load_skid    = 1'b0;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = i_load;
                load_out    = i_load;
            end
        end else if (i_load) begin
            n_skid_valid = 1'b1;
            load_skid    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (out_free && r_skid_valid) begin
            r_out <= r_skid;
        end else if (load_out) begin
            r_out <= i_data;
        end
        if (load_skid) begin
            r_skid <= i_data;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

// ===== rtl/binary_majority_filter_3x3.sv =====
// A result goes to the output register, or to the skid register while that is held.
// Throughput: one item per cycle while o_stall is low; a result trails its input by
// image_width+1 items; a two-word buffer keeps input flowing while one result waits.
// Reset: stream counters and window clear, width returns to min(MAX_WIDTH, 64), height
// to 64; the two line stores are not cleared and hold unknown data until written.
`default_nettype none

module binary_majority_filter_3x3 #(
    parameter int MAX_WIDTH = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic                             i_opcode,
    input  wire logic                             i_pixel_in,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic                                  o_pixel_out,
    output logic [bmf_pkg::ROW_W-1:0]             o_out_row,
    output logic [bmf_pkg::COL_W-1:0]             o_out_col,
    output logic                                  o_frame_last,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [bmf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [bmf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import bmf_pkg::*;

    localparam int AW         = $clog2(MAX_WIDTH);
    localparam int RESET_COLS = (MAX_WIDTH < WIDTH_RESET) ? MAX_WIDTH : WIDTH_RESET;

    logic [AW-1:0]       r_col_last;
    logic [ROW_W-1:0]    r_row_last;
    logic [AW-1:0]       r_ic;
    logic [IN_ROW_W-1:0] r_ir;
    logic [8:0]          r_win;
    logic                r_byp;
    logic [1:0]          r_byp_data;

    logic [AW-1:0]       n_col_last;
    logic [ROW_W-1:0]    n_row_last;
    logic [AW-1:0]       n_ic;
    logic [IN_ROW_W-1:0] n_ir;
    logic [8:0]          n_win;

    logic                accept;
    logic                cfg_wr;
    logic [1:0]          ram_q;
    logic [1:0]          store_q;
    logic                up_bit;
    logic                low_bit;
    logic                new_bit;
    logic [IN_ROW_W-1:0] row_last_ext;
    logic                row_end_emit;
    logic                mid_emit;
    logic                emit;
    logic [IN_ROW_W-1:0] row_full;
    logic [ROW_W-1:0]    row;
    logic [AW-1:0]       col;
    logic                last;
    t_edge_mask          edges;
    logic                vote;
    t_result             result;
    t_result             out_data;
    logic                buf_full;

    assign cfg_wr      = i_cfg_valid;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && !buf_full;
    assign o_stall     = buf_full;

    // Clamp the written frame size to the supported range.
    always_comb begin
        n_col_last = r_col_last;
        n_row_last = r_row_last;
        if (cfg_wr && i_cfg_index == CFG_IMAGE_WIDTH) begin
            if (i_cfg_data[WIDTH_W-1:0] == '0) begin
                n_col_last = '0;
            end else if (int'(i_cfg_data[WIDTH_W-1:0]) > MAX_WIDTH) begin
                n_col_last = AW'(MAX_WIDTH - 1);
            end else begin
                n_col_last = AW'(int'(i_cfg_data[WIDTH_W-1:0]) - 1);
            end
        end
        if (cfg_wr && i_cfg_index == CFG_IMAGE_HEIGHT) begin
            if (i_cfg_data[HEIGHT_W-1:0] == '0) begin
                n_row_last = '0;
            end else begin
                n_row_last = i_cfg_data[HEIGHT_W-1:0] - HEIGHT_W'(1);
            end
        end
    end

    // Line stores read the column of the next item; a same-cycle write is forwarded.
    assign store_q = r_byp ? r_byp_data : ram_q;
    assign up_bit  = store_q[1];
    assign low_bit = store_q[0];

    assign row_last_ext = {1'b0, r_row_last};
    assign new_bit = (i_opcode == OP_PIXEL) && (r_ir <= row_last_ext) && i_pixel_in;
    assign n_win   = {new_bit, low_bit, up_bit, r_win[8:3]};

    // Output position: at the start of a row the last pixel of the row two up,
    // else the pixel one row up and one column left.
    always_comb begin
        row_end_emit = (r_ic == '0) && (r_ir >= IN_ROW_W'(2))
                       && ((r_ir - IN_ROW_W'(2)) <= row_last_ext);
        mid_emit     = (r_ic != '0) && (r_ir != '0)
                       && ((r_ir - IN_ROW_W'(1)) <= row_last_ext);
        emit         = row_end_emit || mid_emit;
        row_full     = row_end_emit ? (r_ir - IN_ROW_W'(2)) : (r_ir - IN_ROW_W'(1));
        row          = row_full[ROW_W-1:0];
        col          = row_end_emit ? r_col_last : (r_ic - AW'(1));
        last         = row_end_emit && (row == r_row_last);
        edges.top    = row != '0;
        edges.bottom = row != r_row_last;
        edges.left   = col != '0;
        edges.right  = col != r_col_last;
    end

    bmf_vote u_vote (
        .i_window (n_win),
        .i_edges  (edges),
        .o_pixel  (vote)
    );

    assign result.pixel = vote;
    assign result.row   = row;
    assign result.col   = COL_W'(col);
    assign result.last  = last;

    // Stream position: restart on a register write or after the frame's last pixel.
    always_comb begin
        n_ic = r_ic;
        n_ir = r_ir;
        if (!i_rst_n || cfg_wr) begin
            n_ic = '0;
            n_ir = '0;
        end else if (accept) begin
            if (last) begin
                n_ic = '0;
                n_ir = '0;
            end else if (r_ic == r_col_last) begin
                n_ic = '0;
                n_ir = r_ir + IN_ROW_W'(1);
            end else begin
                n_ic = r_ic + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= AW'(RESET_COLS - 1);
            r_row_last <= ROW_W'(HEIGHT_RESET - 1);
            r_ic       <= '0;
            r_ir       <= '0;
            r_win      <= '0;
            r_byp      <= 1'b0;
        end else begin
            r_col_last <= n_col_last;
            r_row_last <= n_row_last;
            r_ic       <= n_ic;
            r_ir       <= n_ir;
            r_byp      <= accept && (r_ic == n_ic);
            if (accept) begin
                r_win <= n_win;
            end
        end
    end

    // Forwarded store word.
    always_ff @(posedge i_clk) begin
        r_byp_data <= {low_bit, new_bit};
    end

    // Upper store takes the lower row, lower store takes the new pixel.
    bmf_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (r_ic),
        .i_wr_data ({low_bit, new_bit}),
        .i_rd_addr (n_ic),
        .o_rd_data (ram_q)
    );

    bmf_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept && emit),
        .i_data  (result),
        .o_full  (buf_full),
        .o_valid (o_valid),
        .o_data  (out_data),
        .i_stall (i_stall)
    );

    assign o_pixel_out  = out_data.pixel;
    assign o_out_row    = out_data.row;
    assign o_out_col    = out_data.col;
    assign o_frame_last = out_data.last;

endmodule

`default_nettype wire

// ===== rtl/bmf_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module bmf_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    input  wire logic                             o_stall,
    input  wire logic                             o_valid,
    input  wire logic                             i_stall,
    input  wire logic                             o_pixel_out,
    input  wire logic [bmf_pkg::ROW_W-1:0]        o_out_row,
    input  wire logic [bmf_pkg::COL_W-1:0]        o_out_col,
    input  wire logic                             o_frame_last
);

    // A stalled result word stays in place.
    `ASSERT_CHECK(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_pixel_out) && $stable(o_out_row) && $stable(o_out_col) && $stable(o_frame_last))

    // Input backpressure only arises behind a full output register.
    `ASSERT_CHECK(a_stall_needs_out, i_clk, i_rst_n, o_stall |-> o_valid)

    // Backpressure starts only after the output was held.
    `ASSERT_CHECK(a_stall_cause, i_clk, i_rst_n, $rose(o_stall) |-> $past(o_valid && i_stall))

    // A result into an empty output follows an accepted word.
    `ASSERT_CHECK(a_out_cause, i_clk, i_rst_n, $rose(o_valid) |-> $past(i_valid && !o_stall))

    // The cycle after reset shows an empty, unstalled block.
    `ASSERT_RESET(a_reset_clear, i_clk, $past(!i_rst_n) |-> !o_valid && !o_stall)

endmodule

bind binary_majority_filter_3x3 bmf_checker u_bmf_checker (.*);

`default_nettype wire

// ===== sim/bmf_stream_checker.sv =====
`timescale 1ns / 1ps

module bmf_stream_checker #(
    parameter int MAX_WIDTH = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_stall,
    input  wire logic                           i_opcode,
    input  wire logic                           i_pixel_in,
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_stall,
    input  wire logic                           i_pixel_out,
    input  wire logic [bmf_pkg::ROW_W-1:0]      i_out_row,
    input  wire logic [bmf_pkg::COL_W-1:0]      i_out_col,
    input  wire logic                           i_frame_last,
    input  wire logic                           i_cfg_valid,
    input  wire logic                           i_cfg_ready,
    input  wire logic [bmf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bmf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_checked
);
    import bmf_pkg::*;

    // Shadow copy of the filter state.
    logic [WIDTH_W-1:0]  reg_width;
    logic [HEIGHT_W-1:0] reg_height;
    logic                line_upper [MAX_WIDTH];
    logic                line_lower [MAX_WIDTH];
    logic [8:0]          window;
    int                  in_row;
    int                  in_col;

    // Filtered pixels still owed by the block, oldest first.
    t_result expected_words [$];

    int fail_count = 0;
    int checked    = 0;

    assign o_fail_count = fail_count;
    assign o_checked    = checked;

    initial o_pending = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        fail_count++;
    endtask

    // Majority vote over the in-frame neighbors of one window column slot.
    // The window holds three columns of three rows; bit (slot*3 + row).
    function automatic logic majority_black(input logic [8:0] win, input int cslot,
                                            input int r, input int c,
                                            input int w, input int h);
        int black;
        int total;
        int dr;
        int dc;
        int slot;
        black = 0;
        total = 0;
        for (dr = -1; dr <= 1; dr++) begin
            for (dc = -1; dc <= 1; dc++) begin
                slot = cslot + dc;
                if (!(dr == 0 && dc == 0) && r + dr >= 0 && r + dr < h &&
                    c + dc >= 0 && c + dc < w && slot >= 0 && slot <= 2) begin
                    total++;
                    black += int'(win[slot * 3 + 1 + dr]);
                end
            end
        end
        return (2 * black >= total);
    endfunction

    task automatic reset_predictor();
        reg_width  = WIDTH_W'(WIDTH_RESET);
        reg_height = HEIGHT_W'(HEIGHT_RESET);
        for (int i = 0; i < MAX_WIDTH; i++) begin
            line_upper[i] = 1'b0;
            line_lower[i] = 1'b0;
        end
        window = '0;
        in_row = 0;
        in_col = 0;
        expected_words.delete();
    endtask

    // A register write restarts the frame; line stores and window are kept.
    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_IMAGE_WIDTH) begin
            reg_width = data[WIDTH_W-1:0];
        end else if (idx == CFG_IMAGE_HEIGHT) begin
            reg_height = data[HEIGHT_W-1:0];
        end
        in_row = 0;
        in_col = 0;
    endtask

    // Advance the shadow filter by one input word and queue any result.
    task automatic filter_step(input logic op, input logic pix);
        int         w;
        int         h;
        int         ic;
        int         ir;
        int         orow;
        int         ocol;
        logic [8:0] prev_win;
        logic       up_b;
        logic       low_b;
        logic       new_b;
        logic       res_pix;
        bit         emit;
        bit         last;
        t_result    want;
        w = (reg_width == 0) ? 1 : ((int'(reg_width) > MAX_WIDTH) ? MAX_WIDTH : int'(reg_width));
        h = (reg_height == 0) ? 1 : int'(reg_height);
        ic = in_col % w;
        ir = in_row;
        prev_win = window;
        emit = 1'b0;
        last = 1'b0;
        res_pix = 1'b0;
        orow = 0;
        ocol = 0;

        // Only a pixel word at a frame position carries image data.
        new_b = (op == OP_PIXEL && ir < h) ? pix : 1'b0;
        up_b  = line_upper[ic];
        low_b = line_lower[ic];

        // At the start of a row the last column of the row two back is finished.
        if (ic == 0 && ir >= 2 && ir - 2 < h) begin
            orow = ir - 2;
            ocol = w - 1;
            res_pix = majority_black(prev_win, 2, orow, ocol, w, h);
            emit = 1'b1;
            last = (orow == h - 1);
        end

        window = {new_b, low_b, up_b, prev_win[8:3]};
        line_upper[ic] = low_b;
        line_lower[ic] = new_b;

        // Otherwise the column to the left in the row above is finished.
        if (ic >= 1 && ir >= 1 && ir - 1 < h) begin
            orow = ir - 1;
            ocol = ic - 1;
            res_pix = majority_black(window, 1, orow, ocol, w, h);
            emit = 1'b1;
        end

        if (last) begin
            in_row = 0;
            in_col = 0;
        end else begin
            ic++;
            if (ic >= w) begin
                ic = 0;
                in_row = (ir + 1) & 'h7FF;
            end
            in_col = ic;
        end

        if (emit) begin
            want.pixel = res_pix;
            want.row   = ROW_W'(orow);
            want.col   = COL_W'(ocol);
            want.last  = last;
            expected_words = {expected_words, want};
        end
    endtask

    // Compare one delivered word against the oldest expectation.
    task automatic check_word();
        t_result want;
        checked++;
        if (expected_words.size() == 0) begin
            report_mismatch($sformatf("result word with none expected: row %0d col %0d",
                                      i_out_row, i_out_col));
        end else begin
            want = expected_words.pop_front();
            if (i_pixel_out !== want.pixel)
                report_mismatch($sformatf("pixel at row %0d col %0d: got %b, expected %b",
                                          want.row, want.col, i_pixel_out, want.pixel));
            if (i_out_row !== want.row)
                report_mismatch($sformatf("row: got %0d, expected %0d", i_out_row, want.row));
            if (i_out_col !== want.col)
                report_mismatch($sformatf("col at row %0d: got %0d, expected %0d",
                                          want.row, i_out_col, want.col));
            if (i_frame_last !== want.last)
                report_mismatch($sformatf("frame_last at row %0d col %0d: got %b, expected %b",
                                          want.row, want.col, i_frame_last, want.last));
        end
    endtask

    // Results are checked before the same edge's input word is predicted,
    // since a word never yields its result in the cycle it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_predictor();
        end else begin
            if (i_cfg_valid === 1'b1 && i_cfg_ready === 1'b1)
                apply_register(i_cfg_index, i_cfg_data);
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0)
                check_word();
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0)
                filter_step(i_opcode, i_pixel_in);
        end
        o_pending <= expected_words.size();
    end

endmodule

// ===== sim/tb_binary_majority_filter_3x3.sv =====
`timescale 1ns / 1ps

module tb_binary_majority_filter_3x3;
    import bmf_pkg::*;

    localparam int MAX_WIDTH     = 64;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 150;
    localparam int PHASE_WORDS   = 95;
    localparam int CYCLE_LIMIT   = 200000;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  drv_valid     = 1'b0;
    logic                  drv_opcode    = OP_PIXEL;
    logic                  drv_pixel     = 1'b0;
    logic                  drv_stall     = 1'b0;
    logic                  drv_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  drv_cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] drv_cfg_data  = '0;

    logic                  dut_stall;
    logic                  out_valid;
    logic                  out_pixel;
    logic [ROW_W-1:0]      out_row;
    logic [COL_W-1:0]      out_col;
    logic                  out_last;
    logic                  cfg_ready;

    int chk_fails;
    int chk_pending;
    int chk_checked;

    // Stimulus knobs and run statistics.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_len       = 0;
    int hold_reqs      = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int cycle_count    = 0;
    int words_sent     = 0;
    int frames_done    = 0;
    int settings       = 0;
    int cfg_writes     = 0;
    int cur_w          = WIDTH_RESET;
    int cur_h          = HEIGHT_RESET;

    binary_majority_filter_3x3 #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (drv_valid),
        .o_stall      (dut_stall),
        .i_opcode     (drv_opcode),
        .i_pixel_in   (drv_pixel),
        .o_valid      (out_valid),
        .i_stall      (drv_stall),
        .o_pixel_out  (out_pixel),
        .o_out_row    (out_row),
        .o_out_col    (out_col),
        .o_frame_last (out_last),
        .i_cfg_valid  (drv_cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (drv_cfg_index),
        .i_cfg_data   (drv_cfg_data)
    );

    bmf_stream_checker #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (drv_valid),
        .i_in_stall   (dut_stall),
        .i_opcode     (drv_opcode),
        .i_pixel_in   (drv_pixel),
        .i_out_valid  (out_valid),
        .i_out_stall  (drv_stall),
        .i_pixel_out  (out_pixel),
        .i_out_row    (out_row),
        .i_out_col    (out_col),
        .i_frame_last (out_last),
        .i_cfg_valid  (drv_cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (drv_cfg_index),
        .i_cfg_data   (drv_cfg_data),
        .o_fail_count (chk_fails),
        .o_pending    (chk_pending),
        .o_checked    (chk_checked)
    );

    // 4 ns clock.
    always #2 clk = ~clk;

    always @(posedge clk) cycle_count <= cycle_count + 1;

    // Receiver: a requested long hold-off wins, otherwise random stalls.
    always @(posedge clk) begin
        if (hold_reqs != hold_served) begin
            hold_served <= hold_reqs;
            hold_left   <= hold_len;
            drv_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            drv_stall <= 1'b1;
        end else begin
            drv_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog on the whole run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycle_count, chk_pending);
        $display("Test completed with failures");
        $finish;
    end

    // Offer one input word, with an optional random gap first, and wait until
    // it is taken. Valid stays high on return; the caller drives it next.
    task automatic send_word(input logic op, input logic pix);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            drv_valid <= 1'b0;
            @(posedge clk);
        end
        drv_valid  <= 1'b1;
        drv_opcode <= op;
        drv_pixel  <= pix;
        do @(posedge clk); while (dut_stall);
        words_sent++;
    endtask

    // Stop offering words and let every expected result come out.
    task automatic wait_for_drain();
        drv_valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_for_drain();
        drv_cfg_valid <= 1'b1;
        drv_cfg_index <= idx;
        drv_cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        drv_cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // Write both registers; the unused upper data bits of the width get noise.
    task automatic set_geometry(input logic [WIDTH_W-1:0] wv, input logic [HEIGHT_W-1:0] hv);
        write_reg(CFG_IMAGE_WIDTH, {3'($urandom_range(7)), wv});
        write_reg(CFG_IMAGE_HEIGHT, hv);
        cur_w = (wv == 0) ? 1 : ((int'(wv) > MAX_WIDTH) ? MAX_WIDTH : int'(wv));
        cur_h = (hv == 0) ? 1 : int'(hv);
        settings++;
    endtask

    // One frame of random pixels followed by its drain words. noise_pct flips
    // the opcode against the position; cut_at >= 0 stops the frame early.
    task automatic run_frame(input int w, input int h, input int density,
                             input int noise_pct, input int cut_at);
        int   n_pix;
        int   n_all;
        logic op;
        logic pix;
        bit   flip;
        n_pix = w * h;
        n_all = n_pix + w + 1;
        for (int k = 0; k < n_all && k != cut_at; k++) begin
            pix  = ($urandom_range(99) < density);
            flip = (noise_pct != 0) && ($urandom_range(99) < noise_pct);
            if (k < n_pix)
                op = flip ? OP_DRAIN : OP_PIXEL;
            else
                op = flip ? OP_PIXEL : OP_DRAIN;
            send_word(op, pix);
        end
        if (cut_at < 0) frames_done++;
    endtask

    // Random frames under one idling profile. Most frames are well formed;
    // some carry opcode noise and some are cut short and restarted.
    task automatic run_phase(input int idle_pct, input int stall_pct,
                             input int first_w, input int first_h,
                             input bit with_hold, input bit with_pause);
        int                  start_words;
        int                  frame_idx;
        int                  density;
        int                  noise;
        int                  cut;
        bit                  restart;
        logic [WIDTH_W-1:0]  wv;
        logic [HEIGHT_W-1:0] hv;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start_words    = words_sent;
        frame_idx      = 0;
        restart        = 1'b1;
        while (words_sent - start_words < PHASE_WORDS) begin
            if (frame_idx == 0 && first_w >= 0) begin
                set_geometry(WIDTH_W'(first_w), HEIGHT_W'(first_h));
            end else if (restart || $urandom_range(99) < 45) begin
                case ($urandom_range(19))
                    0:       wv = 7'd0;
                    1:       wv = 7'd64;
                    2:       wv = 7'($urandom_range(65, 127));
                    3:       wv = 7'($urandom_range(9, 63));
                    default: wv = 7'($urandom_range(1, 8));
                endcase
                case ($urandom_range(9))
                    0:       hv = 10'd0;
                    1:       hv = 10'($urandom_range(7, 20));
                    default: hv = 10'($urandom_range(1, 6));
                endcase
                // Wide frames stay short so that the run length stays bounded.
                if (wv > 7'd8 && hv > 10'd2) hv = 10'($urandom_range(1, 2));
                set_geometry(wv, hv);
            end
            restart = 1'b0;
            case ($urandom_range(4))
                0:       density = 0;
                1:       density = 100;
                2:       density = 15;
                3:       density = 85;
                default: density = 50;
            endcase
            noise = ($urandom_range(3) == 0) ? 6 : 0;
            cut   = -1;
            if ($urandom_range(9) == 0) begin
                cut     = $urandom_range(1, cur_w * cur_h + cur_w);
                restart = 1'b1;
            end
            // Long receiver hold-off while words keep coming.
            if (with_hold && frame_idx == 2) begin
                hold_len = HOLD_CYCLES;
                hold_reqs++;
            end
            // Sender pauses until the block has delivered everything.
            if (with_pause && frame_idx == 3) wait_for_drain();
            run_frame(cur_w, cur_h, density, noise, cut);
            frame_idx++;
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Fill every line store entry at the reset width of 64, while the
        // receiver holds off long enough for the block to stall its input.
        write_reg(CFG_IMAGE_HEIGHT, 10'd1);
        cur_w = WIDTH_RESET;
        cur_h = 1;
        settings++;
        hold_len = HOLD_CYCLES;
        hold_reqs++;
        run_frame(cur_w, cur_h, 50, 0, -1);

        // Zero width and height act as one: a lone pixel has no neighbors.
        set_geometry(7'd0, 10'd0);
        send_word(OP_PIXEL, 1'b0);
        send_word(OP_DRAIN, 1'b0);
        send_word(OP_DRAIN, 1'b1);
        frames_done++;

        // Single row of two.
        set_geometry(7'd2, 10'd0);
        send_word(OP_PIXEL, 1'b1);
        send_word(OP_PIXEL, 1'b0);
        repeat (3) send_word(OP_DRAIN, 1'b0);
        frames_done++;

        // 3x2 with a drain word inside the frame (reads as white) and a pixel
        // word in the drain (ignored).
        set_geometry(7'd3, 10'd2);
        send_word(OP_PIXEL, 1'b1);
        send_word(OP_PIXEL, 1'b1);
        send_word(OP_PIXEL, 1'b1);
        send_word(OP_DRAIN, 1'b1);
        send_word(OP_PIXEL, 1'b0);
        send_word(OP_PIXEL, 1'b1);
        send_word(OP_PIXEL, 1'b1);
        repeat (3) send_word(OP_DRAIN, 1'b0);
        frames_done++;

        // Tall frame, one pixel wide.
        set_geometry(7'd1, 10'd24);
        run_frame(cur_w, cur_h, 50, 0, -1);

        run_phase(31, 51, -1, -1, 1'b1, 1'b0);
        run_phase(51, 31, -1, -1, 1'b1, 1'b0);
        // Width beyond the line store clamps to 64.
        run_phase(0, 0, 127, 1, 1'b0, 1'b1);

        wait_for_drain();

        $display("Covered %0d frames, %0d input words, %0d geometry settings (%0d writes).",
                 frames_done, words_sent, settings, cfg_writes);
        $display("Checked %0d result words under sender gaps, receiver stalls and hold-offs.",
                 chk_checked);
        if (chk_fails == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bmf_pkg.sv
rtl/bmf_ram.sv
rtl/bmf_vote.sv
rtl/bmf_out_buf.sv
rtl/binary_majority_filter_3x3.sv
rtl/bmf_checker.sv
sim/bmf_stream_checker.sv
sim/tb_binary_majority_filter_3x3.sv
